/* sv/lkhc_pkg.sv */
// ----------------------------------------------------------------------------
// lkhc_pkg
// shared types and constants of the keyed handle cache: entry layout, request
// and result records, request codes and stream widths
// ----------------------------------------------------------------------------
package lkhc_pkg;

	localparam int KEY_W   = 64;
	localparam int PAY_W   = 32;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 4;

	// request codes carried in req_type
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	// one stored entry, key in the low bits
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [PAY_W-1:0]   payload;
		logic [KEY_W-1:0]   key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic               req_type;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
		logic [STAMP_W-1:0] frame_stamp;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [PAY_W-1:0]  found_payload;
		logic              evicted;
		logic [PAY_W-1:0]  evicted_payload;
	} res_t;

	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 72;

endpackage

/* sv/lru_keyed_handle_cache_core.sv */
// ----------------------------------------------------------------------------
// lru_keyed_handle_cache_core
// timing: an insert into a free entry, or a lookup on an empty cache, skips the scan;
//   a lookup scans the filled entries up to the first key match, an insert into a
//   full cache scans every entry; the result then passes the output register
// throughput: one transaction at a time; the scan is set by the single read port
//   of the entry memory, one entry per cycle
// reset: clears the fill count and control state only; entry memory holds no reset
// ----------------------------------------------------------------------------
module lru_keyed_handle_cache_core
	import lkhc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// key[63:0], payload[95:64], frame_stamp[127:96]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type[0]
	input  logic [0:0]             s_axis_tuser,
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// hit[0], slot[4:1], found_payload[36:5], evicted[37],
	// evicted_payload[69:38], zero fill[71:70]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int IW = $clog2(ENTRIES);

	// unpacked request
	req_t               req;
	// sequencer <-> output register
	logic               done;
	res_t               res;
	logic               out_free;
	// sequencer <-> entry memory
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;
	// output register
	logic               m_valid_q;
	res_t               m_res_q;

	assign req.req_type    = s_axis_tuser[0];
	assign req.key         = s_axis_tdata[KEY_W-1:0];
	assign req.payload     = s_axis_tdata[KEY_W+PAY_W-1:KEY_W];
	assign req.frame_stamp = s_axis_tdata[KEY_W+PAY_W+STAMP_W-1:KEY_W+PAY_W];

	// key, payload and stamp of each entry share one memory word
	lkhc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lkhc_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req       (req),
		.req_ready (s_axis_tready),
		.out_free  (out_free),
		.done      (done),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// output register parts the result side from the sequencer, so a new
	// request is taken while the previous result waits for m_axis_tready
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && done) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_res_q.evicted_payload, m_res_q.evicted,
		m_res_q.found_payload, m_res_q.slot, m_res_q.hit};

endmodule

/* sv/lkhc_ram.sv */
// ----------------------------------------------------------------------------
// lkhc_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module lkhc_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/lkhc_ctrl.sv */
// ----------------------------------------------------------------------------
// lkhc_ctrl
// request sequencer: scans the entry memory one entry per cycle, matches keys
// or tracks the oldest stamp, and writes the updated entry back
// ----------------------------------------------------------------------------
module lkhc_ctrl
	import lkhc_pkg::*;
#(
	parameter int ENTRIES = 16,
	localparam int IW = $clog2(ENTRIES),
	localparam int CW = $clog2(ENTRIES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  req_t               req,
	output logic               req_ready,
	input  logic               out_free,
	output logic               done,
	output res_t               res,
	output logic               mem_we,
	output logic [IW-1:0]      mem_waddr,
	output logic [ENTRY_W-1:0] mem_wdata,
	output logic               mem_re,
	output logic [IW-1:0]      mem_raddr,
	input  logic [ENTRY_W-1:0] mem_rdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	req_t               req_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      limit_q;
	logic [CW-1:0]      issue_q;
	logic               vld_s1;
	logic               last_s1;
	logic               first_s1;
	logic [IW-1:0]      idx_s1;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [IW-1:0]      best_idx_q;
	logic [PAY_W-1:0]   best_pay_q;
	res_t               res_q;

	entry_t             rd_ent;
	entry_t             wr_ent;
	res_t               res_d;
	logic               full;
	logic               accept;
	logic               is_ins;
	logic               quick;
	logic               start;
	logic [CW-1:0]      start_limit;
	logic               issue_go;
	logic [IW-1:0]      issue_idx;
	logic [CW-1:0]      issue_next;
	logic               issue_last;
	logic               scan_cmp;
	logic               key_match;
	logic               take;
	logic [IW-1:0]      vic_idx;
	logic [PAY_W-1:0]   vic_pay;
	logic               lk_hit;
	logic               scan_end;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [IW-1:0] idx);
		logic [IW+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

	assign rd_ent      = entry_t'(mem_rdata);
	assign full        = (fill_q == CW'(ENTRIES));
	assign accept      = req_valid && (state_q == ST_IDLE);
	assign is_ins      = (req.req_type == REQ_INSERT);
	// insert into a free entry, or lookup into an empty cache: no scan
	assign quick       = accept && ((is_ins && !full) || (!is_ins && (fill_q == '0)));
	assign start       = accept && !quick;
	assign start_limit = is_ins ? CW'(ENTRIES) : fill_q;

	// read issue: entry 0 on the accept cycle, then one per cycle
	assign issue_go   = start || ((state_q == ST_SCAN) && (issue_q < limit_q));
	assign issue_idx  = (state_q == ST_IDLE) ? '0 : issue_q[IW-1:0];
	assign issue_next = (state_q == ST_IDLE) ? CW'(1) : issue_q + CW'(1);
	assign issue_last = (issue_next == ((state_q == ST_IDLE) ? start_limit : limit_q));

	assign mem_re    = issue_go;
	assign mem_raddr = issue_idx;

	// compare stage on the returned entry
	assign scan_cmp  = (state_q == ST_SCAN) && vld_s1;
	assign key_match = (rd_ent.key == req_q.key);
	assign take      = first_s1 || (rd_ent.stamp < best_stamp_q);
	assign vic_idx   = take ? idx_s1 : best_idx_q;
	assign vic_pay   = take ? rd_ent.payload : best_pay_q;
	assign lk_hit    = scan_cmp && (req_q.req_type == REQ_LOOKUP) && key_match;
	assign scan_end  = scan_cmp && (lk_hit || last_s1);

	always_comb begin
		mem_we       = 1'b0;
		mem_waddr    = idx_s1;
		wr_ent.key     = req_q.key;
		wr_ent.payload = req_q.payload;
		wr_ent.stamp   = req_q.frame_stamp;
		res_d        = '0;
		if (quick && is_ins) begin
			mem_we         = 1'b1;
			mem_waddr      = fill_q[IW-1:0];
			wr_ent.key     = req.key;
			wr_ent.payload = req.payload;
			wr_ent.stamp   = req.frame_stamp;
			res_d.slot     = slot_of(fill_q[IW-1:0]);
		end else if (lk_hit) begin
			mem_we              = 1'b1;
			wr_ent.key          = rd_ent.key;
			wr_ent.payload      = rd_ent.payload;
			res_d.hit           = 1'b1;
			res_d.slot          = slot_of(idx_s1);
			res_d.found_payload = rd_ent.payload;
		end else if (scan_end && (req_q.req_type == REQ_INSERT)) begin
			mem_we                = 1'b1;
			mem_waddr             = vic_idx;
			res_d.evicted         = 1'b1;
			res_d.slot            = slot_of(vic_idx);
			res_d.evicted_payload = vic_pay;
		end
		mem_wdata = wr_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			issue_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue_go;
			if (issue_go) begin
				issue_q <= issue_next;
			end
			if (quick && is_ins) begin
				fill_q <= fill_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (quick) begin
						state_q <= ST_DONE;
					end else if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= issue_idx;
		last_s1  <= issue_last;
		first_s1 <= (state_q == ST_IDLE);
		if (accept) begin
			req_q   <= req;
			limit_q <= start_limit;
		end
		if (scan_cmp && take) begin
			best_stamp_q <= rd_ent.stamp;
			best_idx_q   <= idx_s1;
			best_pay_q   <= rd_ent.payload;
		end
		if (quick || scan_end) begin
			res_q <= res_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign done      = (state_q == ST_DONE);
	assign res       = res_q;

	a_evict_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_end && (req_q.req_type == REQ_INSERT)) |-> full)
		else $error("eviction while free entries remain");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + CW'(1))))
		else $error("fill count moved by more than one");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(ENTRIES))
		else $error("fill count beyond capacity");

	a_no_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_DONE))
		else $error("memory write while result is pending");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cmp |-> $past(mem_re))
		else $error("compare stage without a preceding read");

endmodule

/* dv/tb_lru_keyed_handle_cache_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_keyed_handle_cache_core
// self-checking bench for the keyed handle cache: a shadow cache predicts every
// lookup and insert, a monitor compares each result transaction field by field,
// with directed corner cases, an output hold-off and random traffic under
// changing idle profiles on both streams
// ----------------------------------------------------------------------------
module tb_lru_keyed_handle_cache_core;
	import lkhc_pkg::*;

	localparam int ENTRIES       = 16;
	localparam int KEY_POOL      = 24;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = ENTRIES + 8;
	localparam int RANDOM_ITEMS  = 125;
	localparam int TIMEOUT_NS    = 2_000_000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// key[63:0], payload[95:64], frame_stamp[127:96]
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	// req_type[0]
	logic [0:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// hit[0], slot[4:1], found_payload[36:5], evicted[37], evicted_payload[69:38]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow copy of the cache contents
	logic [KEY_W-1:0]   cache_keys     [ENTRIES];
	logic [PAY_W-1:0]   cache_payloads [ENTRIES];
	logic [STAMP_W-1:0] cache_stamps   [ENTRIES];
	int                 cache_fill = 0;

	// results still owed by the block, oldest first
	res_t pending_res [$];

	int errors        = 0;
	int n_lookups     = 0;
	int n_hits        = 0;
	int n_inserts     = 0;
	int n_evictions   = 0;
	int n_results     = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;

	logic [STAMP_W-1:0] frame_now = '0;
	logic [KEY_W-1:0]   key_pool [KEY_POOL];

	lru_keyed_handle_cache_core #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow cache: returns the result of one request and updates the copy
	function automatic res_t cache_predict(req_t r);
		res_t res;
		int   victim;
		res = '0;
		if (r.req_type == REQ_LOOKUP) begin
			// first matching filled entry wins, its stamp is refreshed
			for (int i = 0; i < cache_fill; i++) begin
				if (!res.hit && cache_keys[i] == r.key) begin
					res.hit           = 1'b1;
					res.slot          = i[SLOT_W-1:0];
					res.found_payload = cache_payloads[i];
					cache_stamps[i]   = r.frame_stamp;
				end
			end
		end else begin
			if (cache_fill < ENTRIES) begin
				victim = cache_fill;
				cache_fill++;
			end else begin
				// smallest stamp, plain unsigned compare, lowest index on a tie
				victim = 0;
				for (int i = 1; i < ENTRIES; i++) begin
					if (cache_stamps[i] < cache_stamps[victim])
						victim = i;
				end
				res.evicted         = 1'b1;
				res.evicted_payload = cache_payloads[victim];
			end
			cache_keys[victim]     = r.key;
			cache_payloads[victim] = r.payload;
			cache_stamps[victim]   = r.frame_stamp;
			res.slot               = victim[SLOT_W-1:0];
		end
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// offers one request transaction after a random gap, returns at its accept edge
	task automatic send_req(input logic req_type, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] payload, input logic [STAMP_W-1:0] stamp);
		req_t r;
		res_t p;
		r.req_type    = req_type;
		r.key         = key;
		r.payload     = payload;
		r.frame_stamp = stamp;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {stamp, payload, key};
		s_axis_tuser  <= req_type;
		do
			@(posedge clk);
		while (!s_axis_tready);
		p = cache_predict(r);
		pending_res.push_back(p);
		if (req_type == REQ_LOOKUP) begin
			n_lookups++;
			n_hits += int'(p.hit);
		end else begin
			n_inserts++;
			n_evictions += int'(p.evicted);
		end
	endtask

	// stops offering and waits until every owed result has come back
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
	endtask

	// random request: keys mostly from a small pool so lookups hit and
	// inserts duplicate, stamps mostly a slow frame counter with jumps and wraps
	task automatic send_random_item();
		logic             req;
		logic [KEY_W-1:0] key;
		int               pick;
		req  = ($urandom_range(99) < 40) ? REQ_INSERT : REQ_LOOKUP;
		pick = $urandom_range(KEY_POOL - 1);
		if (req == REQ_INSERT) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					key            = {$urandom, $urandom};
					key_pool[pick] = key;
				end
				5, 6, 7: key = key_pool[pick];
				default: key = {$urandom, $urandom};
			endcase
		end else begin
			key = ($urandom_range(3) == 0) ? {$urandom, $urandom} : key_pool[pick];
		end
		case ($urandom_range(15))
			0:       frame_now = $urandom;
			1:       frame_now = 32'hffff_fff8 + $urandom_range(7);
			default: frame_now = frame_now + $urandom_range(2);
		endcase
		send_req(req, key, $urandom, frame_now);
	endtask

	// corner cases: empty cache, field extremes, duplicates, tie and wrap eviction
	task automatic test_directed_cases();
		logic [KEY_W-1:0] last_key;
		last_key = '0;
		// lookup on an empty cache misses
		send_req(REQ_LOOKUP, '1, '1, 32'd1);
		send_req(REQ_INSERT, '0, '0, '0);
		send_req(REQ_INSERT, '1, '1, '1);
		// hits on both extremes and a miss, payload on a lookup is ignored
		send_req(REQ_LOOKUP, '0, 32'h1234_5678, 32'd100);
		send_req(REQ_LOOKUP, '1, '0, 32'd100);
		send_req(REQ_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 32'd100);
		// duplicate key goes into a fresh entry, lookup still returns the lower one
		send_req(REQ_INSERT, '0, 32'hdead_beef, 32'd7);
		send_req(REQ_LOOKUP, '0, '0, 32'd101);
		// fill the rest with one shared stamp so the first eviction is a tie
		for (int i = 3; i < ENTRIES; i++) begin
			last_key    = {$urandom, $urandom};
			key_pool[i] = last_key;
			send_req(REQ_INSERT, last_key, $urandom, 32'd7);
		end
		send_req(REQ_INSERT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa, 32'd200);
		// hit on the last entry, the longest scan
		send_req(REQ_LOOKUP, last_key, '0, 32'd201);
		// stamp zero after large stamps is the oldest, taken by the next insert
		send_req(REQ_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555, '0);
		send_req(REQ_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001, 32'd300);
		wait_for_results();
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_output_holdoff();
		hold_requests++;
		repeat (20)
			send_random_item();
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int n_items);
		repeat (n_items)
			send_random_item();
		wait_for_results();
	endtask

	// result side ready, with random idling and requested hold-offs
	initial begin : recv_side
		int hold_served;
		int hold_left;
		hold_served   = 0;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result monitor: one transaction against the oldest owed result
	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hit             = m_axis_tdata[0];
			got.slot            = m_axis_tdata[4:1];
			got.found_payload   = m_axis_tdata[36:5];
			got.evicted         = m_axis_tdata[37];
			got.evicted_payload = m_axis_tdata[69:38];
			n_results++;
			if (pending_res.size() == 0) begin
				$display("%0t: result with none owed, expected nothing, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_res.pop_front();
				check_field("hit", 32'(want.hit), 32'(got.hit));
				check_field("slot", 32'(want.slot), 32'(got.slot));
				check_field("found_payload", want.found_payload, got.found_payload);
				check_field("evicted", 32'(want.evicted), 32'(got.evicted));
				check_field("evicted_payload", want.evicted_payload, got.evicted_payload);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_lru_keyed_handle_cache_core failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// busy sender, sparse receiver
		send_idle_pct = 7;
		recv_idle_pct = 48;
		test_directed_cases();
		test_output_holdoff();
		test_random_traffic(RANDOM_ITEMS);

		// sparse sender, busy receiver
		send_idle_pct = 48;
		recv_idle_pct = 7;
		test_random_traffic(RANDOM_ITEMS);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(RANDOM_ITEMS);

		// anything arriving now is unowed and flagged by the monitor
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("covered %0d lookups (%0d hits) and %0d inserts (%0d evictions),",
			n_lookups, n_hits, n_inserts, n_evictions);
		$display("%0d results, under three idle profiles and one long output hold-off",
			n_results);
		if (errors == 0)
			$display("tb_lru_keyed_handle_cache_core passed");
		else
			$display("tb_lru_keyed_handle_cache_core failed");
		$finish;
	end

endmodule
